>>> hw/rtl/csvrfs_pkg.sv
`timescale 1ns / 1ps
package csvrfs_pkg;

  localparam int MaxColumnsDef   = 32;
  localparam int NullMaxBytesDef = 8;
  localparam int QDepth          = 4;
  localparam int QPtrW           = $clog2(QDepth);
  localparam int QCntW           = $clog2(QDepth + 1);

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // Configuration register indexes
  localparam logic [3:0] CFG_DELIMITER  = 4'd0;
  localparam logic [3:0] CFG_QUOTE      = 4'd1;
  localparam logic [3:0] CFG_ESCAPE     = 4'd2;
  localparam logic [3:0] CFG_NULL_TEXT  = 4'd3;
  localparam logic [3:0] CFG_NULL_LEN   = 4'd4;
  localparam logic [3:0] CFG_COLUMNS    = 4'd5;
  localparam logic [3:0] CFG_NOT_NULL   = 4'd6;
  localparam logic [3:0] CFG_SKIP_LINES = 4'd7;

  typedef enum logic [1:0] {
    K_DATA   = 2'd0,
    K_FIELD  = 2'd1,
    K_RECORD = 2'd2,
    K_DONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    E_OK      = 3'd0,
    E_QUOTE   = 3'd1,
    E_EXTRA   = 3'd2,
    E_MISSING = 3'd3,
    E_SKIP    = 3'd4
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [4:0]  idx;
    logic        nul;
    err_e        err;
  } result_t;

  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } qstat_t;

endpackage

>>> hw/rtl/csvrfs_front.sv
`timescale 1ns / 1ps
module csvrfs_front #(
  parameter int MaxColumns   = csvrfs_pkg::MaxColumnsDef,
  parameter int NullMaxBytes = csvrfs_pkg::NullMaxBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [3:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eoi_i,
  output logic                push_o,
  output csvrfs_pkg::entry_t  entry_o
);
  import csvrfs_pkg::*;

  localparam int ColLim = (MaxColumns < 32) ? MaxColumns : 32;
  localparam logic [5:0] ColLimV = 6'(ColLim);
  localparam logic [3:0] NullMaxV = 4'(NullMaxBytes);

  logic [7:0]  delim_q, quote_q, esc_q;
  logic [63:0] ntext_q;
  logic [3:0]  nlen_q;
  logic [5:0]  cols_q;
  logic [31:0] nnmask_q;
  logic [15:0] skip_q;

  logic [15:0] sc_q, sc_d;
  logic        ssc_q, ssc_d, iq_q, iq_d, acr_q, acr_d, ep_q, ep_d, ro_q, ro_d;
  logic [4:0]  fp_q, fp_d;
  logic [5:0]  fs_q, fs_d;
  logic [3:0]  rl_q, rl_d;
  logic        nm_q, nm_d;

  logic [5:0]  eff;
  logic [1:0]  n;
  result_t     res [2];
  logic        consumed, skip_rest, do_q, do_u;
  logic [7:0]  b;

  always_comb begin
    eff = cols_q;
    if (eff < 6'd1) eff = 6'd1;
    if (eff > ColLimV) eff = ColLimV;
  end

  function automatic logic null_f(logic nm, logic [3:0] rl, logic [3:0] nl,
                                  logic [4:0] fp, logic [31:0] mask);
    null_f = nm && (nl <= NullMaxV) && (rl == nl) && !mask[fp];
  endfunction

  function automatic result_t mk(kind_e k, logic [7:0] d, logic [4:0] i,
                                 logic nl, err_e e);
    result_t r;
    r.kind = k;
    r.data = d;
    r.idx  = i;
    r.nul  = nl;
    r.err  = e;
    mk = r;
  endfunction

  always_comb begin
    sc_d = sc_q; ssc_d = ssc_q; iq_d = iq_q; acr_d = acr_q; ep_d = ep_q;
    ro_d = ro_q; fp_d = fp_q; fs_d = fs_q; rl_d = rl_q; nm_d = nm_q;
    n = 2'd0;
    res[0] = '0;
    res[1] = '0;
    consumed = 1'b0;
    skip_rest = 1'b0;
    do_q = 1'b0;
    do_u = 1'b0;
    b = in_byte_i;
    if (in_eoi_i) begin
      if (sc_d < skip_q && ssc_d) sc_d = sc_d + 16'd1;
      if (ro_q) begin
        if (ep_q && esc_q == quote_q) iq_d = 1'b0;
        res[n[0]] = mk(K_RECORD, 8'd0, fp_d,
                       null_f(nm_d, rl_d, nlen_q, fp_d, nnmask_q),
                       iq_d ? E_QUOTE : (fs_d > eff) ? E_EXTRA :
                       (fs_d < eff) ? E_MISSING : E_OK);
        n = n + 2'd1;
      end
      res[n[0]] = mk(K_DONE, 8'd0, 5'd0, 1'b0, (sc_d < skip_q) ? E_SKIP : E_OK);
      n = n + 2'd1;
      // Return to the post-reset state; registers stay
      sc_d = '0; ssc_d = 1'b0; acr_d = 1'b0; fp_d = '0; fs_d = 6'd1;
      iq_d = 1'b0; ep_d = 1'b0; ro_d = 1'b0; rl_d = '0; nm_d = 1'b1;
    end else begin
      if (sc_d < skip_q) begin
        if (ssc_d) begin
          ssc_d = 1'b0;
          sc_d = sc_d + 16'd1;
          if (b == CH_LF) consumed = 1'b1;
        end
        if (!consumed && sc_d < skip_q) begin
          if (b == CH_CR) ssc_d = 1'b1;
          else if (b == CH_LF) sc_d = sc_d + 16'd1;
          consumed = 1'b1;
        end
      end
      if (!consumed) begin
        if (acr_d) begin
          acr_d = 1'b0;
          if (b == CH_LF) skip_rest = 1'b1;
        end
        if (!skip_rest) begin
          if (ep_d) begin
            ep_d = 1'b0;
            if (b == quote_q || b == esc_q) begin
              nm_d = nm_d && (rl_d < NullMaxV) && (rl_d < nlen_q) &&
                     (ntext_q[rl_d[2:0]*8 +: 8] == b);
              if (rl_d < 4'd9) rl_d = rl_d + 4'd1;
              res[n[0]] = mk(K_DATA, b, fp_d, 1'b0, E_OK);
              n = n + 2'd1;
            end else if (esc_q == quote_q) begin
              iq_d = 1'b0;
              do_u = 1'b1;
            end else begin
              res[n[0]] = mk(K_DATA, esc_q, fp_d, 1'b0, E_OK);
              n = n + 2'd1;
              do_q = 1'b1;
            end
          end else if (iq_d) begin
            do_q = 1'b1;
          end else begin
            do_u = 1'b1;
          end
          if (do_q) begin
            nm_d = nm_d && (rl_d < NullMaxV) && (rl_d < nlen_q) &&
                   (ntext_q[rl_d[2:0]*8 +: 8] == b);
            if (rl_d < 4'd9) rl_d = rl_d + 4'd1;
            if (b == esc_q) ep_d = 1'b1;
            else if (b == quote_q) iq_d = 1'b0;
            else begin
              res[n[0]] = mk(K_DATA, b, fp_d, 1'b0, E_OK);
              n = n + 2'd1;
            end
          end
          if (do_u) begin
            ro_d = 1'b1;
            if (b == quote_q) begin
              iq_d = 1'b1;
              nm_d = nm_d && (rl_d < NullMaxV) && (rl_d < nlen_q) &&
                     (ntext_q[rl_d[2:0]*8 +: 8] == b);
              if (rl_d < 4'd9) rl_d = rl_d + 4'd1;
            end else if (b == CH_CR || b == CH_LF) begin
              res[n[0]] = mk(K_RECORD, 8'd0, fp_d,
                             null_f(nm_d, rl_d, nlen_q, fp_d, nnmask_q),
                             iq_d ? E_QUOTE : (fs_d > eff) ? E_EXTRA :
                             (fs_d < eff) ? E_MISSING : E_OK);
              n = n + 2'd1;
              fp_d = '0; fs_d = 6'd1; iq_d = 1'b0; ep_d = 1'b0; ro_d = 1'b0;
              rl_d = '0; nm_d = 1'b1;
              if (b == CH_CR) acr_d = 1'b1;
            end else if (b == delim_q) begin
              res[n[0]] = mk(K_FIELD, 8'd0, fp_d,
                             null_f(nm_d, rl_d, nlen_q, fp_d, nnmask_q), E_OK);
              n = n + 2'd1;
              if ({1'b0, fp_d} + 6'd1 < eff) fp_d = fp_d + 5'd1;
              if (fs_d < 6'd63) fs_d = fs_d + 6'd1;
              rl_d = '0;
              nm_d = 1'b1;
            end else begin
              nm_d = nm_d && (rl_d < NullMaxV) && (rl_d < nlen_q) &&
                     (ntext_q[rl_d[2:0]*8 +: 8] == b);
              if (rl_d < 4'd9) rl_d = rl_d + 4'd1;
              res[n[0]] = mk(K_DATA, b, fp_d, 1'b0, E_OK);
              n = n + 2'd1;
            end
          end
        end
      end
    end
  end

  assign push_o     = in_valid_i && in_ready_i && (n != 2'd0);
  assign entry_o.two = n[1];
  assign entry_o.r0  = res[0];
  assign entry_o.r1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= 8'd44; quote_q <= 8'd34; esc_q <= 8'd34; ntext_q <= '0;
      nlen_q <= '0; cols_q <= 6'd1; nnmask_q <= '0; skip_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DELIMITER:  delim_q  <= cfg_data_i[7:0];
        CFG_QUOTE:      quote_q  <= cfg_data_i[7:0];
        CFG_ESCAPE:     esc_q    <= cfg_data_i[7:0];
        CFG_NULL_TEXT:  ntext_q  <= cfg_data_i;
        CFG_NULL_LEN:   nlen_q   <= cfg_data_i[3:0];
        CFG_COLUMNS:    cols_q   <= cfg_data_i[5:0];
        CFG_NOT_NULL:   nnmask_q <= cfg_data_i[31:0];
        CFG_SKIP_LINES: skip_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0; ssc_q <= 1'b0; iq_q <= 1'b0; acr_q <= 1'b0; ep_q <= 1'b0;
      ro_q <= 1'b0; fp_q <= '0; fs_q <= 6'd1; rl_q <= '0; nm_q <= 1'b1;
    end else if (in_valid_i && in_ready_i) begin
      sc_q <= sc_d; ssc_q <= ssc_d; iq_q <= iq_d; acr_q <= acr_d; ep_q <= ep_d;
      ro_q <= ro_d; fp_q <= fp_d; fs_q <= fs_d; rl_q <= rl_d; nm_q <= nm_d;
    end
  end

endmodule

>>> hw/rtl/csvrfs_queue.sv
`timescale 1ns / 1ps
module csvrfs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  csvrfs_pkg::entry_t entry_i,
  input  logic               pop_i,
  output csvrfs_pkg::entry_t head_o,
  output csvrfs_pkg::qstat_t stat_o
);
  import csvrfs_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> hw/rtl/csvrfs_back.sv
`timescale 1ns / 1ps
module csvrfs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csvrfs_pkg::entry_t  head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output csvrfs_pkg::result_t res_o,
  output logic                last_o
);
  import csvrfs_pkg::*;

  // Second result of a two-result entry is being shown
  logic sel_q;

  assign valid_o = !empty_i;
  assign res_o   = sel_q ? head_i.r1 : head_i.r0;
  assign last_o  = sel_q || !head_i.two;
  assign pop_o   = valid_o && ready_i && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (valid_o && ready_i) begin
      sel_q <= !last_o;
    end
  end

endmodule

>>> hw/rtl/csv_record_field_splitter_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Signals                              Contents
// s_axis    in         tvalid/tready/tdata[7:0]/tlast       byte_in; tlast = end_of_input
// m_axis    out        tvalid/tready/tdata[23:0]/tuser/tlast one result word; tuser = kind
// cfg       in         cfg_valid/cfg_ready/cfg_index/cfg_data register write, always ready
//
// Each input byte is parsed in the cycle it is accepted: one byte per cycle.
// Every byte yields zero, one or two result words; the back end sends one word
// per cycle while the receiver is ready, so a byte yielding two words sends them in turn.
// A four-entry queue separates parser and output; the input stalls only when it fills.
// Reset is asynchronous, active low; it restores default registers and parser state.
module csv_record_field_splitter_unit #(
  parameter int MaxColumns   = csvrfs_pkg::MaxColumnsDef,
  parameter int NullMaxBytes = csvrfs_pkg::NullMaxBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data_byte, field_index, field_is_null, error_code
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);
  import csvrfs_pkg::*;

  logic    push, pop;
  entry_t  entry, head;
  qstat_t  qstat;
  result_t res;

  // Registers are written in any cycle; the host must write only while idle
  assign cfg_ready_o   = 1'b1;
  // Hold the input while the queue has no free entry
  assign s_axis_tready = !qstat.full;

  csvrfs_front #(
    .MaxColumns  (MaxColumns),
    .NullMaxBytes(NullMaxBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eoi_i   (s_axis_tlast),
    .push_o     (push),
    .entry_o    (entry)
  );

  csvrfs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  csvrfs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .empty_i(qstat.empty),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .res_o  (res),
    .last_o (m_axis_tlast)
  );

  // Pack the result word, lowest field first
  assign m_axis_tdata = {7'd0, res.err, res.nul, res.idx, res.data};
  assign m_axis_tuser = res.kind;

  // Stream done is always the final word of its byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == K_DONE) |-> m_axis_tlast)
    else $error("stream done word without last");

  // Data words never carry an error code
  a_data_noerr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == K_DATA) |-> (m_axis_tdata[16:14] == E_OK))
    else $error("data word with error code");

  // Queue occupancy stays within its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCntW'(QDepth))
    else $error("queue overflow");

  // No push while full
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !push)
    else $error("push into full queue");

endmodule

>>> test/csvrfs_checker.sv
`timescale 1ns / 1ps
module csvrfs_checker
  import csvrfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_last_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [23:0] m_data_i,
  input  logic [1:0]  m_user_i,
  input  logic        m_last_i,
  output int          fails_o,
  output int          pending_o
);

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic [4:0] idx;
    logic       nul;
    err_e       err;
    logic       last;
  } word_t;

  word_t words_due[$];

  logic [7:0]  delim, quote, escape;
  logic [63:0] null_txt;
  logic [3:0]  null_cnt;
  logic [5:0]  cols;
  logic [31:0] not_null;
  logic [15:0] skip_lines;

  logic [15:0] skipped;
  logic        skip_cr, quoted_now, after_cr, esc_pend, rec_open, null_ok;
  logic [4:0]  fpos;
  logic [5:0]  fseen;
  logic [3:0]  raw_len;

  function automatic logic [5:0] eff_cols();
    logic [5:0] c;
    c = cols;
    if (c < 6'd1) c = 6'd1;
    if (c > 6'(MaxColumnsDef)) c = 6'(MaxColumnsDef);
    if (c > 6'd32) c = 6'd32;
    return c;
  endfunction

  task automatic add_word(kind_e k, logic [7:0] d, logic [4:0] i, logic n, err_e e);
    word_t w;
    w.kind = k; w.data = d; w.idx = i; w.nul = n; w.err = e; w.last = 1'b0;
    words_due.push_back(w);
  endtask

  task automatic clear_field();
    raw_len = 0;
    null_ok = 1'b1;
  endtask

  task automatic clear_record();
    fpos = 0; fseen = 1; quoted_now = 0; esc_pend = 0; rec_open = 0;
    clear_field();
  endtask

  task automatic clear_parser();
    skipped = 0; skip_cr = 0; after_cr = 0;
    clear_record();
  endtask

  task automatic track_raw(logic [7:0] b);
    if (raw_len < NullMaxBytesDef && raw_len < null_cnt) begin
      if (null_txt[8*raw_len +: 8] != b) null_ok = 1'b0;
    end else begin
      null_ok = 1'b0;
    end
    if (raw_len < 9) raw_len++;
  endtask

  function automatic logic is_null();
    if (!null_ok || null_cnt > NullMaxBytesDef || raw_len != null_cnt) return 1'b0;
    return !not_null[fpos];
  endfunction

  task automatic close_field();
    add_word(K_FIELD, 8'd0, fpos, is_null(), E_OK);
    if (fpos + 6'd1 < eff_cols()) fpos++;
    if (fseen < 63) fseen++;
    clear_field();
  endtask

  task automatic close_record();
    err_e e;
    e = E_OK;
    if (quoted_now) e = E_QUOTE;
    else if (fseen > eff_cols()) e = E_EXTRA;
    else if (fseen < eff_cols()) e = E_MISSING;
    add_word(K_RECORD, 8'd0, fpos, is_null(), e);
    clear_record();
  endtask

  task automatic plain_byte(logic [7:0] b);
    rec_open = 1'b1;
    if (b == quote) begin
      quoted_now = 1'b1;
      track_raw(b);
    end else if (b == CH_CR) begin
      close_record();
      after_cr = 1'b1;
    end else if (b == CH_LF) begin
      close_record();
    end else if (b == delim) begin
      close_field();
    end else begin
      track_raw(b);
      add_word(K_DATA, b, fpos, 1'b0, E_OK);
    end
  endtask

  task automatic quoted_byte(logic [7:0] b);
    track_raw(b);
    if (b == escape) esc_pend = 1'b1;
    else if (b == quote) quoted_now = 1'b0;
    else add_word(K_DATA, b, fpos, 1'b0, E_OK);
  endtask

  task automatic parse(logic [7:0] b);
    if (after_cr) begin
      after_cr = 1'b0;
      if (b == CH_LF) return;
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (b == quote || b == escape) begin
        track_raw(b);
        add_word(K_DATA, b, fpos, 1'b0, E_OK);
      end else if (escape == quote) begin
        quoted_now = 1'b0;
        plain_byte(b);
      end else begin
        add_word(K_DATA, escape, fpos, 1'b0, E_OK);
        quoted_byte(b);
      end
    end else if (quoted_now) begin
      quoted_byte(b);
    end else begin
      plain_byte(b);
    end
  endtask

  // Predict the words one accepted input word causes; flag the final one.
  task automatic predict_words(logic [7:0] b, logic eoi);
    int n0;
    logic eaten;
    n0 = words_due.size();
    eaten = 1'b0;
    if (eoi) begin
      if (skipped < skip_lines && skip_cr) skipped++;
      skip_cr = 0;
      after_cr = 0;
      if (rec_open) begin
        if (esc_pend && escape == quote) quoted_now = 1'b0;
        esc_pend = 1'b0;
        close_record();
      end
      add_word(K_DONE, 8'd0, 5'd0, 1'b0, (skipped < skip_lines) ? E_SKIP : E_OK);
      clear_parser();
    end else begin
      if (skipped < skip_lines) begin
        if (skip_cr) begin
          skip_cr = 0;
          skipped++;
          if (b == CH_LF) eaten = 1'b1;
        end
        if (!eaten && skipped < skip_lines) begin
          if (b == CH_CR) skip_cr = 1'b1;
          else if (b == CH_LF) skipped++;
          eaten = 1'b1;
        end
      end
      if (!eaten) parse(b);
    end
    if (words_due.size() > n0) words_due[words_due.size()-1].last = 1'b1;
  endtask

  task automatic report(string what);
    $display("%0t mismatch: %s", $time, what);
    fails_o++;
  endtask

  initial begin
    fails_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    if (!rst_ni) begin
      delim = 8'd44; quote = 8'd34; escape = 8'd34;
      null_txt = 0; null_cnt = 0; cols = 1; not_null = 0; skip_lines = 0;
      clear_parser();
      words_due.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DELIMITER:  delim = cfg_data_i[7:0];
          CFG_QUOTE:      quote = cfg_data_i[7:0];
          CFG_ESCAPE:     escape = cfg_data_i[7:0];
          CFG_NULL_TEXT:  null_txt = cfg_data_i;
          CFG_NULL_LEN:   null_cnt = cfg_data_i[3:0];
          CFG_COLUMNS:    cols = cfg_data_i[5:0];
          CFG_NOT_NULL:   not_null = cfg_data_i[31:0];
          CFG_SKIP_LINES: skip_lines = cfg_data_i[15:0];
          default: ;
        endcase
      end
      // Check the output side before predicting this edge's input word.
      if (m_valid_i && m_ready_i) begin
        if (words_due.size() == 0) begin
          report($sformatf("unexpected word kind %0d tdata %h", m_user_i, m_data_i));
        end else begin
          w = words_due.pop_front();
          if (m_user_i != w.kind)
            report($sformatf("kind %0d, want %0d", m_user_i, w.kind));
          if (m_data_i[7:0] != w.data)
            report($sformatf("data %h, want %h", m_data_i[7:0], w.data));
          if (m_data_i[12:8] != w.idx)
            report($sformatf("field index %0d, want %0d", m_data_i[12:8], w.idx));
          if (m_data_i[13] != w.nul)
            report($sformatf("null flag %0b, want %0b", m_data_i[13], w.nul));
          if (m_data_i[16:14] != w.err)
            report($sformatf("error %0d, want %0d", m_data_i[16:14], w.err));
          if (m_data_i[23:17] != 0)
            report($sformatf("pad bits %h not zero", m_data_i[23:17]));
          if (m_last_i != w.last)
            report($sformatf("last %0b, want %0b", m_last_i, w.last));
        end
      end
      if (s_valid_i && s_ready_i) predict_words(s_data_i, s_last_i);
      pending_o = words_due.size();
    end
  end

endmodule

>>> test/csv_record_field_splitter_unit_tb.sv
`timescale 1ns / 1ps
module csv_record_field_splitter_unit_tb;
  import csvrfs_pkg::*;

  localparam int LimitCycles = 400000;
  localparam int ItemTarget  = 1800;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0]  s_axis_tdata;                 // byte_in
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [23:0] m_axis_tdata;                 // data_byte, field_index, field_is_null, error_code
  logic [1:0]  m_axis_tuser;                 // kind
  int          fails, pending, cycles, items, phases, records;
  logic        calm;   // no idling on either side while set

  // Copy of the current settings, used only to shape the stimulus.
  logic [7:0]  cur_delim, cur_quote, cur_escape;
  logic [63:0] cur_null;
  logic [3:0]  cur_null_len;
  logic [5:0]  cur_cols;

  csv_record_field_splitter_unit DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  csvrfs_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .s_last_i(s_axis_tlast), .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser), .m_last_i(m_axis_tlast),
    .fails_o(fails), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stall about 31 percent of the time unless calm.
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= calm || ($urandom_range(0, 99) >= 31);
  end

  // Push one word into the parser; return at the edge that takes it.
  task automatic send(logic [7:0] b, logic eoi);
    logic hs;
    if (!calm) begin
      while ($urandom_range(0, 99) < 31) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoi;
    do begin
      @(negedge clk_i);
      hs = s_axis_tready;
      @(posedge clk_i);
    end while (!hs);
    items++;
  endtask

  // Hold the input until every predicted word has come out, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    logic hs;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      hs = cfg_ready_o;
      @(posedge clk_i);
    end while (!hs);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [7:0] dl, logic [7:0] qt, logic [7:0] es, logic [63:0] nt,
                           logic [3:0] nl, logic [5:0] cc, logic [31:0] nn, logic [15:0] sk);
    drain();
    write_reg(CFG_DELIMITER, {56'd0, dl});
    write_reg(CFG_QUOTE, {56'd0, qt});
    write_reg(CFG_ESCAPE, {56'd0, es});
    write_reg(CFG_NULL_TEXT, nt);
    write_reg(CFG_NULL_LEN, {60'd0, nl});
    write_reg(CFG_COLUMNS, {58'd0, cc});
    write_reg(CFG_NOT_NULL, {32'd0, nn});
    write_reg(CFG_SKIP_LINES, {48'd0, sk});
    cur_delim = dl; cur_quote = qt; cur_escape = es;
    cur_null = nt; cur_null_len = nl; cur_cols = cc;
    phases++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0:       return cur_delim;
      1:       return cur_quote;
      2:       return cur_escape;
      3:       return CH_CR;
      4:       return CH_LF;
      5:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  // One field: plain text, quoted text with escapes, a copy of the null text, or noise.
  task automatic send_field();
    int n;
    n = $urandom_range(0, 4);
    case ($urandom_range(0, 5))
      0, 1: for (int i = 0; i < n; i++) send(8'($urandom_range(97, 122)), 1'b0);
      2: begin
        send(cur_quote, 1'b0);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: begin send(cur_escape, 1'b0); send(cur_quote, 1'b0); end
            1: begin send(cur_escape, 1'b0); send(cur_escape, 1'b0); end
            2: send(pick_char(), 1'b0);
            default: send(8'($urandom_range(97, 122)), 1'b0);
          endcase
        end
        if ($urandom_range(0, 9) != 0) send(cur_quote, 1'b0);
      end
      3, 4: for (int i = 0; i < cur_null_len && i < 8; i++) send(cur_null[8*i +: 8], 1'b0);
      default: for (int i = 0; i < n; i++) send(pick_char(), 1'b0);
    endcase
  endtask

  // One record: about column_count fields, ended by LF, CR or CRLF.
  task automatic send_record();
    int nf;
    nf = int'(cur_cols) + $urandom_range(0, 2) - 1;
    if (nf < 1) nf = 1;
    if (nf > 34) nf = 34;
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send(cur_delim, 1'b0);
      send_field();
    end
    case ($urandom_range(0, 2))
      0: send(CH_LF, 1'b0);
      1: send(CH_CR, 1'b0);
      default: begin send(CH_CR, 1'b0); send(CH_LF, 1'b0); end
    endcase
    records++;
  endtask

  initial begin
    int goal;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    calm = 1'b0; cycles = 0; items = 0; phases = 0; records = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: doubled quote, CRLF, lone CR, empty line, escape closing at end.
    configure(8'd44, 8'd34, 8'd34, 64'h4c4c_554e, 4'd4, 6'd2, 32'd0, 16'd1);
    send_text("h\r");
    send_text("a,\"b\"\"c\"\r\nNULL,x\r\r\n");
    send_text("\"q\"\"");
    send(8'd0, 1'b1);
    // Escape unlike quote, unterminated quote at end, extremes of the byte.
    configure(8'd255, 8'd39, 8'd92, 64'd0, 4'd0, 6'd1, 32'hffff_ffff, 16'd0);
    send_text("'a\\'\\\\\\z");
    send(8'hff, 1'b0); send(8'h00, 1'b0); send(8'hff, 1'b1);

    while (items < ItemTarget) begin
      case (phases % 6)
        0: configure(8'd44, 8'd34, 8'd34, {$urandom, $urandom}, 4'($urandom_range(0, 8)),
                     6'($urandom_range(1, 4)), $urandom, 16'($urandom_range(0, 2)));
        1: configure(8'd0, 8'd255, 8'd255, 64'hffff_ffff_ffff_ffff, 4'd8, 6'd32,
                     32'd0, 16'd0);
        2: configure(8'($urandom), 8'($urandom), 8'($urandom), 64'h6f6e_2e,
                     4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)), 32'h5555_aaaa,
                     16'($urandom_range(0, 3)));
        3: configure(8'd59, 8'd39, 8'd92, {$urandom, $urandom}, 4'($urandom_range(0, 3)),
                     6'($urandom_range(1, 6)), 32'd0, 16'($urandom_range(0, 1)));
        4: configure(8'd9, 8'd34, 8'd34, 64'd0, 4'd15, 6'd0, 32'd0, 16'hffff);
        default: configure(8'd44, 8'd34, 8'd34, 64'h2f5c, 4'd2, 6'd63, 32'h0000_0001,
                           16'd0);
      endcase
      calm = (phases == 5);
      goal = items + ((phases % 6 == 4) ? 40 : 160);
      while (items < goal) begin
        if ($urandom_range(0, 15) == 0) send(8'($urandom), $urandom_range(0, 7) == 0);
        else send_record();
      end
      if ($urandom_range(0, 3) != 0) send_field();
      send(8'($urandom), 1'b1);
      calm = 1'b0;
    end

    drain();
    $display("Covered %0d input words, %0d generated records, %0d settings.",
             items, records, phases);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
